FILE: rtl/tbi_pkg.sv
// Package: sizes, controller states and the command/status bundles of the time bucket index.
`timescale 1ns / 1ps

package tbi_pkg;

   localparam int TICKS = 1024;
   localparam int SLOTS = 32;

   localparam int TICK_FIELD_W = 17;
   localparam int ID_W         = 16;

   localparam int TICK_W = (TICKS > 1) ? $clog2(TICKS) : 1;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = (TICKS * SLOTS > 1) ? $clog2(TICKS * SLOTS) : 1;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic signed [TICK_FIELD_W-1:0] TICK_LAST = TICK_FIELD_W'(TICKS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_FILL,
      ST_Q_CHK,
      ST_Q_SLOT,
      ST_Q_LOAD,
      ST_Q_EMPTY
   } state_type;

   typedef struct packed {
      logic take_req;
      logic clr_write;
      logic fill_rd;
      logic append;
      logic tick_next;
      logic slot_rd;
      logic slot_next;
      logic rsp_load;
      logic rsp_empty;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_query;
      logic req_skip;
      logic clear_done;
      logic tick_done;
      logic fill_full;
      logic fill_zero;
      logic slot_last;
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/tbi_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface tbi_req_if;
   logic                                         valid;
   logic                                         ready;
   logic                                         op;
   logic signed [tbi_pkg::TICK_FIELD_W-1:0]      tick_first;
   logic signed [tbi_pkg::TICK_FIELD_W-1:0]      tick_last;
   logic        [tbi_pkg::ID_W-1:0]              event_id;

   modport source (output valid, op, tick_first, tick_last, event_id, input ready);
   modport sink   (input valid, op, tick_first, tick_last, event_id, output ready);
endinterface

interface tbi_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tbi_pkg::ID_W-1:0]   stored_id;
   logic                       has_entry;
   logic                       last;

   modport source (output valid, stored_id, has_entry, last, input ready);
   modport sink   (input valid, stored_id, has_entry, last, output ready);
endinterface

FILE: rtl/tbi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module tbi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tbi_datapath.sv
// Datapath: tick/slot counters, fill count and slot memories, response register.
`timescale 1ns / 1ps

module tbi_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tbi_pkg::cmd_type     cmd,
   output tbi_pkg::status_type  status,
   tbi_req_if.sink              req,
   tbi_rsp_if.source            rsp
);

   logic signed [tbi_pkg::TICK_FIELD_W-1:0] lo_s;
   logic signed [tbi_pkg::TICK_FIELD_W-1:0] hi_s;
   logic                                    query_bad;

   logic [tbi_pkg::TICK_W-1:0] cur_ff, cur_in;
   logic [tbi_pkg::TICK_W-1:0] hi_ff;
   logic [tbi_pkg::SLOT_W-1:0] k_ff, k_in;
   logic [tbi_pkg::ID_W-1:0]   id_ff;

   logic [tbi_pkg::CNT_W-1:0]  fill_rd;
   logic                       fill_we;
   logic [tbi_pkg::CNT_W-1:0]  fill_wdata;

   logic [tbi_pkg::ADDR_W-1:0] bucket_base;
   logic [tbi_pkg::ADDR_W-1:0] slot_waddr;
   logic [tbi_pkg::ADDR_W-1:0] slot_raddr;
   logic [tbi_pkg::ID_W-1:0]   slot_rd;

   logic                       rsp_valid_ff;
   logic [tbi_pkg::ID_W-1:0]   rsp_id_ff;
   logic                       rsp_has_ff;
   logic                       rsp_last_ff;

   // Clip the add range to the tick table and flag out-of-range query ticks
   always_comb begin
      lo_s = req.tick_first[tbi_pkg::TICK_FIELD_W-1] ? '0 : req.tick_first;
      hi_s = (req.tick_last > tbi_pkg::TICK_LAST) ? tbi_pkg::TICK_LAST : req.tick_last;
      query_bad = req.tick_first[tbi_pkg::TICK_FIELD_W-1] ||
                  ($unsigned(req.tick_first) >= tbi_pkg::TICK_FIELD_W'(tbi_pkg::TICKS));
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.take_req && req.valid) begin
         cur_in = (req.op == tbi_pkg::OP_QUERY) ? req.tick_first[tbi_pkg::TICK_W-1:0]
                                                : lo_s[tbi_pkg::TICK_W-1:0];
      end else if (cmd.tick_next) begin
         cur_in = cur_ff + tbi_pkg::TICK_W'(1);
      end

      k_in = k_ff;
      if (cmd.take_req && req.valid) begin
         k_in = '0;
      end else if (cmd.slot_next) begin
         k_in = k_ff + tbi_pkg::SLOT_W'(1);
      end
   end

   // cur_ff doubles as the sweep pointer of the post-reset clear
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         k_ff   <= '0;
      end else begin
         cur_ff <= cur_in;
         k_ff   <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req && req.valid) begin
         hi_ff <= hi_s[tbi_pkg::TICK_W-1:0];
         id_ff <= req.event_id;
      end
   end

   assign fill_we    = cmd.clr_write || cmd.append;
   assign fill_wdata = cmd.clr_write ? '0 : fill_rd + tbi_pkg::CNT_W'(1);

   tbi_ram #(
      .WIDTH (tbi_pkg::CNT_W),
      .DEPTH (tbi_pkg::TICKS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (cur_ff),
      .wr_data (fill_wdata),
      .rd_en   (cmd.fill_rd),
      .rd_addr (cur_ff),
      .rd_data (fill_rd)
   );

   assign bucket_base = tbi_pkg::ADDR_W'(cur_ff) * tbi_pkg::ADDR_W'(tbi_pkg::SLOTS);
   assign slot_waddr  = bucket_base + tbi_pkg::ADDR_W'(fill_rd);
   assign slot_raddr  = bucket_base + tbi_pkg::ADDR_W'(k_ff);

   tbi_ram #(
      .WIDTH (tbi_pkg::ID_W),
      .DEPTH (tbi_pkg::TICKS * tbi_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (slot_waddr),
      .wr_data (id_ff),
      .rd_en   (cmd.slot_rd),
      .rd_addr (slot_raddr),
      .rd_data (slot_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load || cmd.rsp_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_id_ff   <= slot_rd;
         rsp_has_ff  <= 1'b1;
         rsp_last_ff <= status.slot_last;
      end else if (cmd.rsp_empty) begin
         rsp_id_ff   <= '0;
         rsp_has_ff  <= 1'b0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.stored_id = rsp_id_ff;
   assign rsp.has_entry = rsp_has_ff;
   assign rsp.last      = rsp_last_ff;
   assign req.ready     = cmd.take_req;

   always_comb begin
      status.req_valid  = req.valid;
      status.req_query  = (req.op == tbi_pkg::OP_QUERY);
      status.req_skip   = (req.op == tbi_pkg::OP_QUERY) ? query_bad : (lo_s > hi_s);
      status.clear_done = (cur_ff == tbi_pkg::TICK_W'(tbi_pkg::TICKS - 1));
      status.tick_done  = (cur_ff == hi_ff);
      status.fill_full  = (fill_rd >= tbi_pkg::CNT_W'(tbi_pkg::SLOTS));
      status.fill_zero  = (fill_rd == '0);
      status.slot_last  = ((tbi_pkg::CNT_W'(k_ff) + tbi_pkg::CNT_W'(1)) == fill_rd);
      status.rsp_free   = !rsp_valid_ff || rsp.ready;
   end

endmodule

FILE: rtl/tbi_ctrl.sv
// Controller: state machine sequencing the clear sweep, adds and queries.
`timescale 1ns / 1ps

module tbi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  tbi_pkg::status_type  status,
   output tbi_pkg::cmd_type     cmd
);

   tbi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbi_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tbi_pkg::ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            cmd.tick_next = 1'b1;
            if (status.clear_done) begin
               state_in = tbi_pkg::ST_IDLE;
            end
         end
         tbi_pkg::ST_IDLE: begin
            cmd.take_req = 1'b1;
            if (status.req_valid) begin
               priority if (status.req_query && status.req_skip) begin
                  state_in = tbi_pkg::ST_Q_EMPTY;
               end else if (status.req_query) begin
                  state_in = tbi_pkg::ST_Q_FILL;
               end else if (!status.req_skip) begin
                  state_in = tbi_pkg::ST_ADD_RD;
               end else begin
                  state_in = tbi_pkg::ST_IDLE;
               end
            end
         end
         tbi_pkg::ST_ADD_RD: begin
            cmd.fill_rd = 1'b1;
            state_in    = tbi_pkg::ST_ADD_WR;
         end
         tbi_pkg::ST_ADD_WR: begin
            // a full bucket keeps its contents, the sweep moves on regardless
            cmd.append    = !status.fill_full;
            cmd.tick_next = 1'b1;
            state_in = status.tick_done ? tbi_pkg::ST_IDLE : tbi_pkg::ST_ADD_RD;
         end
         tbi_pkg::ST_Q_FILL: begin
            cmd.fill_rd = 1'b1;
            state_in    = tbi_pkg::ST_Q_CHK;
         end
         tbi_pkg::ST_Q_CHK: begin
            state_in = status.fill_zero ? tbi_pkg::ST_Q_EMPTY : tbi_pkg::ST_Q_SLOT;
         end
         tbi_pkg::ST_Q_SLOT: begin
            cmd.slot_rd = 1'b1;
            state_in    = tbi_pkg::ST_Q_LOAD;
         end
         tbi_pkg::ST_Q_LOAD: begin
            // read data holds while the response register is still occupied
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (status.slot_last) begin
                  state_in = tbi_pkg::ST_IDLE;
               end else begin
                  cmd.slot_next = 1'b1;
                  state_in      = tbi_pkg::ST_Q_SLOT;
               end
            end
         end
         tbi_pkg::ST_Q_EMPTY: begin
            if (status.rsp_free) begin
               cmd.rsp_empty = 1'b1;
               state_in      = tbi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbi_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/time_bucket_id_index_top.sv
// Top level of the time bucket ID index: controller plus datapath.
`timescale 1ns / 1ps

// Indexes 16-bit event IDs by time tick: TICKS buckets of up to SLOTS IDs each, with a
// per-bucket fill count. An add request (op 0) appends event_id to every bucket in
// tick_first..tick_last clipped to 0..TICKS-1; full buckets ignore it and it gives no
// response. A query request (op 1) returns the IDs of bucket tick_first in insertion
// order, last set on the final one; an empty bucket or out-of-range tick gives a single
// response with has_entry 0 and last 1. One request is handled at a time. An add reads
// and then writes the fill count memory for each clipped tick; a query of a filled
// bucket reads and checks the fill count, then per stored ID does a registered slot
// memory read and then a load of the response register; a query of an empty bucket
// also reads and checks the fill count first, one of an out-of-range tick does not.
// Response loads wait while the response channel stalls. After reset the block sweeps
// the fill count memory to zero, one bucket a cycle, holding req.ready low until done.

module time_bucket_id_index_top (
   input  logic       clock,
   input  logic       reset,
   tbi_req_if.sink    req,
   tbi_rsp_if.source  rsp
);

   tbi_pkg::cmd_type    cmd;
   tbi_pkg::status_type status;

   tbi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tbi_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

endmodule

FILE: tb/tb_time_bucket_id_index_top.sv
// Testbench for the time bucket ID index: directed table, an overfilled bucket, then random adds and queries.
`timescale 1ns / 1ps

module tb_time_bucket_id_index_top;

   typedef struct packed {
      logic [tbi_pkg::ID_W-1:0] stored_id;
      logic                     has_entry;
      logic                     last;
   } bucket_read_type;

   typedef struct packed {
      logic                                    op;
      logic signed [tbi_pkg::TICK_FIELD_W-1:0] first;
      logic signed [tbi_pkg::TICK_FIELD_W-1:0] last;
      logic [tbi_pkg::ID_W-1:0]                id;
      logic                                    typed;
      bucket_read_type                         want;
   } plan_row_type;

   localparam int PLAN_ROWS = 21;
   localparam bucket_read_type EMPTY_READ = '{stored_id: '0, has_entry: 1'b0, last: 1'b1};

   // typed-in results only where obvious; other rows go through the predictor
   plan_row_type plan [PLAN_ROWS] = '{
      '{tbi_pkg::OP_QUERY, 17'sd0,      17'sd0,      16'h0000, 1'b1, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, -17'sd1,     17'sd0,      16'h0000, 1'b1, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd1024,   17'sd0,      16'h0000, 1'b1, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd65535,  -17'sd65536, 16'hFFFF, 1'b1, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, -17'sd65536, 17'sd65535,  16'hFFFF, 1'b1, EMPTY_READ},
      '{tbi_pkg::OP_ADD,   -17'sd65536, -17'sd1,     16'hFFFF, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_ADD,   17'sd1024,   17'sd65535,  16'hFFFF, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_ADD,   17'sd9,      17'sd3,      16'h1234, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd3,      17'sd0,      16'h0000, 1'b1, EMPTY_READ},
      '{tbi_pkg::OP_ADD,   17'sd0,      17'sd0,      16'h0000, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd0,      17'sd0,      16'h0000, 1'b1,
        '{stored_id: 16'h0000, has_entry: 1'b1, last: 1'b1}},
      '{tbi_pkg::OP_ADD,   17'sd1023,   17'sd65535,  16'hFFFF, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd1023,   17'sd0,      16'h0000, 1'b1,
        '{stored_id: 16'hFFFF, has_entry: 1'b1, last: 1'b1}},
      '{tbi_pkg::OP_ADD,   -17'sd65536, 17'sd2,      16'h5A5A, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd0,      17'sd0,      16'h0000, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd2,      17'sd0,      16'h0000, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_ADD,   17'sd0,      17'sd1023,   16'hA5A5, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd512,    17'sd0,      16'h0000, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd1023,   17'sd0,      16'h0000, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_ADD,   17'sd1023,   -17'sd65536, 16'h8001, 1'b0, EMPTY_READ},
      '{tbi_pkg::OP_QUERY, 17'sd5,      -17'sd1,     16'hFFFF, 1'b0, EMPTY_READ}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   tbi_req_if req_ch ();
   tbi_rsp_if rsp_ch ();

   time_bucket_id_index_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #6 clock = ~clock;

   // shadow copy of the index
   int unsigned              bucket_fill [tbi_pkg::TICKS];
   logic [tbi_pkg::ID_W-1:0] bucket_ids  [tbi_pkg::TICKS][tbi_pkg::SLOTS];
   bucket_read_type          expected_reads [$];

   int  mismatches   = 0;
   int  adds_sent    = 0;
   int  queries_sent = 0;
   int  full_hits    = 0;
   int  reads_seen   = 0;
   bit  quiet        = 1'b0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void expect_read(input bucket_read_type r);
      expected_reads.insert(expected_reads.size(), r);
   endfunction

   function automatic void index_request(input logic op,
                                         input logic signed [tbi_pkg::TICK_FIELD_W-1:0] first,
                                         input logic signed [tbi_pkg::TICK_FIELD_W-1:0] last,
                                         input logic [tbi_pkg::ID_W-1:0] id);
      int lo;
      int hi;
      int unsigned n;
      bucket_read_type r;
      lo = int'(first);
      hi = int'(last);
      if (op == tbi_pkg::OP_ADD) begin
         adds_sent++;
         if (lo < 0) lo = 0;
         if (hi > tbi_pkg::TICKS - 1) hi = tbi_pkg::TICKS - 1;
         for (int t = lo; t <= hi; t++) begin
            if (bucket_fill[t] >= tbi_pkg::SLOTS) begin
               full_hits++;
            end else begin
               bucket_ids[t][bucket_fill[t]] = id;
               bucket_fill[t]++;
            end
         end
      end else begin
         queries_sent++;
         if (lo < 0 || lo >= tbi_pkg::TICKS || bucket_fill[lo] == 0) begin
            expect_read(EMPTY_READ);
         end else begin
            n = bucket_fill[lo];
            for (int unsigned k = 0; k < n; k++) begin
               r.stored_id = bucket_ids[lo][k];
               r.has_entry = 1'b1;
               r.last      = (k + 1 == n);
               expect_read(r);
            end
         end
      end
   endfunction

   // entered just after a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic op,
                               input logic signed [tbi_pkg::TICK_FIELD_W-1:0] first,
                               input logic signed [tbi_pkg::TICK_FIELD_W-1:0] last,
                               input logic [tbi_pkg::ID_W-1:0] id,
                               input logic typed,
                               input bucket_read_type want);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.op         <= op;
      req_ch.tick_first <= first;
      req_ch.tick_last  <= last;
      req_ch.event_id   <= id;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (typed) begin
         queries_sent++;
         expect_read(want);
      end else begin
         index_request(op, first, last, id);
      end
      @(negedge clock);
   endtask

   initial begin : rsp_side
      int stall;
      bucket_read_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         stall = quiet ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         reads_seen++;
         if (expected_reads.size() == 0) begin
            report_mismatch($sformatf("unexpected read id=%h has_entry=%b last=%b",
                                      rsp_ch.stored_id, rsp_ch.has_entry, rsp_ch.last));
         end else begin
            want = expected_reads.pop_front();
            if (rsp_ch.stored_id !== want.stored_id)
               report_mismatch($sformatf("stored_id %h, want %h",
                                         rsp_ch.stored_id, want.stored_id));
            if (rsp_ch.has_entry !== want.has_entry)
               report_mismatch($sformatf("has_entry %b, want %b",
                                         rsp_ch.has_entry, want.has_entry));
            if (rsp_ch.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_ch.last, want.last));
         end
      end
   end

   initial begin : req_side
      logic                                    op;
      logic signed [tbi_pkg::TICK_FIELD_W-1:0] first;
      logic signed [tbi_pkg::TICK_FIELD_W-1:0] last;
      int                                      hot;
      for (int t = 0; t < tbi_pkg::TICKS; t++) bucket_fill[t] = 0;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= tbi_pkg::OP_ADD;
      req_ch.tick_first <= '0;
      req_ch.tick_last  <= '0;
      req_ch.event_id   <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_request(plan[i].op, plan[i].first, plan[i].last, plan[i].id,
                      plan[i].typed, plan[i].want);

      // overfill one bucket, then read it back
      quiet = 1'b1;
      for (int i = 0; i < tbi_pkg::SLOTS + 3; i++)
         send_request(tbi_pkg::OP_ADD, 17'sd700, 17'sd700, 16'($urandom()), 1'b0,
                      EMPTY_READ);
      send_request(tbi_pkg::OP_QUERY, 17'sd700, 17'sd700, 16'h0000, 1'b0, EMPTY_READ);

      for (int i = 0; i < 45; i++) begin
         if (i % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            // well-formed: short ranges around a few busy ticks
            if ($urandom_range(0, 7) == 0) hot = tbi_pkg::TICKS - 3 + $urandom_range(0, 2);
            else hot = $urandom_range(0, 4) * 200 + $urandom_range(0, 2);
            op = ($urandom_range(0, 9) < 6) ? tbi_pkg::OP_ADD : tbi_pkg::OP_QUERY;
            if (op == tbi_pkg::OP_ADD) begin
               first = tbi_pkg::TICK_FIELD_W'(hot - int'($urandom_range(0, 2)));
               last  = tbi_pkg::TICK_FIELD_W'(int'(first) + int'($urandom_range(0, 4)));
            end else begin
               first = tbi_pkg::TICK_FIELD_W'(hot + int'($urandom_range(0, 2)) - 1);
               last  = 17'($urandom());
            end
         end else begin
            op    = 1'($urandom());
            first = 17'($urandom());
            last  = 17'($urandom());
         end
         send_request(op, first, last, 16'($urandom()), 1'b0, EMPTY_READ);
      end
      req_ch.valid <= 1'b0;

      while (expected_reads.size() != 0) @(posedge clock);
      // a late add may still be running; give any stray read time to show
      repeat (2200) @(posedge clock);

      $display("Ran %0d adds (%0d bucket writes refused as full) and %0d queries,",
               adds_sent, full_hits, queries_sent);
      $display("checking %0d reads under random request and response stalls.", reads_seen);
      if (mismatches == 0) begin
         $display("** time_bucket_id_index_top: PASSED **");
      end else begin
         $display("** time_bucket_id_index_top: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("Timeout with %0d reads outstanding", expected_reads.size());
      $display("** time_bucket_id_index_top: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
rtl/tbi_pkg.sv
rtl/tbi_if.sv
rtl/tbi_ram.sv
rtl/tbi_datapath.sv
rtl/tbi_ctrl.sv
rtl/time_bucket_id_index_top.sv
tb/tb_time_bucket_id_index_top.sv
